// ===== rtl/core/sha1_hash_engine_assert.svh =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Property wrappers sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define SHA1HE_ASSERT_HOLDS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SHA1HE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Microcode word layout, operation and condition codes, the control store
// and the SHA-1 constants shared by the engine's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1he_pkg;

  typedef logic [3:0] op_t;
  typedef logic [2:0] cond_t;
  typedef logic [3:0] upc_t;
  typedef logic [6:0] rnd_t;
  typedef logic [4:0][31:0] chain_t;

  // Datapath operations
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_DATA  = 4'd2;
  localparam op_t OP_P80   = 4'd3;
  localparam op_t OP_PZERO = 4'd4;
  localparam op_t OP_PLEN  = 4'd5;
  localparam op_t OP_ROUND = 4'd6;
  localparam op_t OP_ADD   = 4'd7;
  localparam op_t OP_EMIT  = 4'd8;

  // Jump conditions
  localparam cond_t C_NEXT    = 3'd0;
  localparam cond_t C_ALWAYS  = 3'd1;
  localparam cond_t C_NOIN    = 3'd2;
  localparam cond_t C_FULL    = 3'd3;
  localparam cond_t C_NOTLAST = 3'd4;
  localparam cond_t C_OBUSY   = 3'd5;
  localparam cond_t C_RNDMORE = 3'd6;
  localparam cond_t C_RET     = 3'd7;

  // Microcode addresses
  localparam upc_t U_WAIT   = 4'd0;
  localparam upc_t U_DATA   = 4'd1;
  localparam upc_t U_BRANCH = 4'd2;
  localparam upc_t U_P80    = 4'd3;
  localparam upc_t U_PZERO  = 4'd4;
  localparam upc_t U_PLEN   = 4'd5;
  localparam upc_t U_EMIT   = 4'd6;
  localparam upc_t U_LOOP   = 4'd7;
  localparam upc_t U_RND    = 4'd8;
  localparam upc_t U_FIN    = 4'd9;

  localparam rnd_t RND_LAST = 7'd79;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] LEN_START   = 7'd56;

  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  call;
    upc_t  target;
    upc_t  ret;
  } uword_t;

  typedef struct packed {
    op_t  op;
    rnd_t rnd;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic plast;
  } status_t;

  // Control store: jump to target when the condition holds, else step on; C_RET returns to the saved address.
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t uw;
    unique case (pc)
      U_WAIT:   uw = '{OP_LOAD,  C_NOIN,    1'b0, U_WAIT, U_WAIT};
      U_DATA:   uw = '{OP_DATA,  C_FULL,    1'b1, U_RND,  U_DATA};
      U_BRANCH: uw = '{OP_NOP,   C_NOTLAST, 1'b0, U_WAIT, U_WAIT};
      U_P80:    uw = '{OP_P80,   C_FULL,    1'b1, U_RND,  U_PZERO};
      U_PZERO:  uw = '{OP_PZERO, C_FULL,    1'b1, U_RND,  U_PZERO};
      U_PLEN:   uw = '{OP_PLEN,  C_ALWAYS,  1'b1, U_RND,  U_EMIT};
      U_EMIT:   uw = '{OP_EMIT,  C_OBUSY,   1'b0, U_EMIT, U_EMIT};
      U_LOOP:   uw = '{OP_NOP,   C_ALWAYS,  1'b0, U_WAIT, U_WAIT};
      U_RND:    uw = '{OP_ROUND, C_RNDMORE, 1'b0, U_RND,  U_RND};
      U_FIN:    uw = '{OP_ADD,   C_RET,     1'b0, U_WAIT, U_WAIT};
      default:  uw = '{OP_NOP,   C_ALWAYS,  1'b0, U_WAIT, U_WAIT};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-granular SHA-1 over a word stream, microcoded control, digest words
// delivered from an output bank.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)            | tlast
//  in_     | slave     | data_word[31:0], byte_count[34:32]   | last_word
//  out_    | master    | digest_word[31:0], word_index[34:32] | last_of_digest
//
//  A word that completes no block passes through accept, gather and branch.
//  Each full 64-byte block adds 80 rounds of the single round unit, the
//  chaining add and, after a gather step, a repeat of it. The last word
//  adds padding steps and one or two compressions. Reset restores the
//  initial chaining value.
//  The five digest words sit in an output bank; a new digest waits only
//  while that bank still drains.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_engine import sha1he_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], byte_count[34:32], zero fill
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast
);

  ctl_t        ctl;
  status_t     stat;
  logic        in_fire;
  logic        out_fire;
  logic [31:0] wt;
  chain_t      chain;
  chain_t      obank_r;
  logic [2:0]  oidx_r;
  logic        obusy_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  sha1he_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .obusy   (obusy_r),
    .stat    (stat),
    .ready   (in_tready),
    .ctl     (ctl)
  );

  sha1he_msgbuf u_msgbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_word  (in_tdata[31:0]),
    .in_count (in_tdata[34:32]),
    .in_last  (in_tlast),
    .wt       (wt),
    .stat     (stat)
  );

  sha1he_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .wt    (wt),
    .chain (chain)
  );

  // output bank: word 0 always at the head
  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      obank_r <= chain;
    end else if (out_fire) begin
      for (int i = 0; i < 4; i++) begin
        obank_r[i] <= obank_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obusy_r <= 1'b0;
      oidx_r  <= '0;
    end else if (ctl.op == OP_EMIT) begin
      obusy_r <= 1'b1;
      oidx_r  <= '0;
    end else if (out_fire) begin
      oidx_r <= oidx_r + 3'd1;
      if (oidx_r == 3'd4) begin
        obusy_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = obusy_r;
  assign out_tdata  = {5'd0, oidx_r, obank_r[0]};
  assign out_tlast  = (oidx_r == 3'd4);

`include "sha1_hash_engine_assert.svh"

  `SHA1HE_ASSERT_NEXT(a_leave_wait, in_fire, !in_tready, "sequencer stayed ready after a transaction")
  `SHA1HE_ASSERT_HOLDS(a_emit_free, ctl.op == OP_EMIT, !obusy_r, "digest emitted over a busy bank")
  `SHA1HE_ASSERT_NEXT(a_bank_drained, out_fire && out_tlast, !out_tvalid, "bank still valid after final word")

endmodule

`default_nettype wire

// ===== rtl/core/sha1he_seq.sv =====
// ----------------------------------------------------------------------------
// SHA-1 microcode sequencer
// Step counter over the control store, round counter and return register
// for the shared compression routine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1he_seq import sha1he_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    obusy,
  input  status_t stat,
  output logic    ready,
  output ctl_t    ctl
);

  upc_t   pc_r, pc_nxt;
  upc_t   ret_r, ret_nxt;
  rnd_t   rnd_r, rnd_nxt;
  uword_t uw;
  logic   taken;

  assign uw    = ucode_rom(pc_r);
  assign ready = (pc_r == U_WAIT);

  always_comb begin
    unique case (uw.cond)
      C_NEXT:    taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_NOIN:    taken = !in_fire;
      C_FULL:    taken = stat.full;
      C_NOTLAST: taken = !stat.plast;
      C_OBUSY:   taken = obusy;
      C_RNDMORE: taken = (rnd_r != RND_LAST);
      C_RET:     taken = 1'b1;
    endcase
  end

  always_comb begin
    ctl.rnd = rnd_r;
    // drop a load without a transaction and an emit while the bank drains
    if ((uw.op == OP_LOAD && !in_fire) || (uw.op == OP_EMIT && obusy)) begin
      ctl.op = OP_NOP;
    end else begin
      ctl.op = uw.op;
    end
  end

  always_comb begin
    if (uw.cond == C_RET) begin
      pc_nxt = ret_r;
    end else if (taken) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
    ret_nxt = (taken && uw.call) ? uw.ret : ret_r;
    if (ctl.op == OP_ROUND) begin
      rnd_nxt = (rnd_r == RND_LAST) ? '0 : rnd_r + 7'd1;
    end else begin
      rnd_nxt = rnd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= U_WAIT;
      ret_r <= U_WAIT;
      rnd_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      ret_r <= ret_nxt;
      rnd_r <= rnd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1he_msgbuf.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message buffer
// Gathers message and padding bytes into a 64-byte block and, during the
// rounds, shifts it as the 16-word message schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1he_msgbuf import sha1he_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_count,
  input  logic        in_last,
  output logic [31:0] wt,
  output status_t     stat
);

  logic [7:0]  byte_r [64];
  logic [31:0] pend_r;
  logic [2:0]  pcnt_r;
  logic        plast_r;
  logic [6:0]  fill_r, fill_nxt;
  logic [63:0] blen_r;

  logic [2:0]  cnt_sat;
  logic [6:0]  room;
  logic [2:0]  take;
  logic [6:0]  zlim;
  logic [15:0][31:0] words;
  logic [31:0] wnew;
  logic        wr_en  [64];
  logic [7:0]  wr_dat [64];

  assign cnt_sat = (in_count > 3'd4) ? 3'd4 : in_count;
  assign room    = BLOCK_BYTES - fill_r;
  assign take    = ({4'd0, pcnt_r} < room) ? pcnt_r : room[2:0];
  assign zlim    = (fill_r <= LEN_START) ? LEN_START : BLOCK_BYTES;

  always_comb begin
    for (int j = 0; j < 16; j++) begin
      words[j] = {byte_r[4*j], byte_r[4*j+1], byte_r[4*j+2], byte_r[4*j+3]};
    end
  end

  assign wt   = words[0];
  assign wnew = {words[13][30:0] ^ words[8][30:0] ^ words[2][30:0] ^ words[0][30:0],
                 words[13][31] ^ words[8][31] ^ words[2][31] ^ words[0][31]};

  always_comb begin
    unique case (ctl.op)
      OP_DATA:  fill_nxt = fill_r + {4'd0, take};
      OP_P80:   fill_nxt = fill_r + 7'd1;
      OP_PZERO: fill_nxt = zlim;
      OP_PLEN:  fill_nxt = BLOCK_BYTES;
      OP_ADD:   fill_nxt = '0;
      default:  fill_nxt = fill_r;
    endcase
  end

  assign stat.full  = (fill_nxt == BLOCK_BYTES);
  assign stat.plast = plast_r;

  // per-byte write enables and data for the gathering operations
  always_comb begin
    for (int p = 0; p < 64; p++) begin
      logic [6:0] pos;
      logic [6:0] d;
      pos = 7'(p);
      d   = pos - fill_r;
      unique case (ctl.op)
        OP_DATA: begin
          wr_en[p]  = (pos >= fill_r) && (d < {4'd0, take});
          wr_dat[p] = pend_r[{2'd3 - d[1:0], 3'b000} +: 8];
        end
        OP_P80: begin
          wr_en[p]  = (pos == fill_r);
          wr_dat[p] = 8'h80;
        end
        OP_PZERO: begin
          wr_en[p]  = (pos >= fill_r) && (pos < zlim);
          wr_dat[p] = 8'h00;
        end
        OP_PLEN: begin
          wr_en[p]  = (pos >= LEN_START);
          wr_dat[p] = blen_r[{3'd7 - pos[2:0], 3'b000} +: 8];
        end
        default: begin
          wr_en[p]  = 1'b0;
          wr_dat[p] = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_ROUND) begin
      // advance the schedule by one word
      for (int p = 0; p < 60; p++) begin
        byte_r[p] <= byte_r[p+4];
      end
      byte_r[60] <= wnew[31:24];
      byte_r[61] <= wnew[23:16];
      byte_r[62] <= wnew[15:8];
      byte_r[63] <= wnew[7:0];
    end else begin
      for (int p = 0; p < 64; p++) begin
        if (wr_en[p]) begin
          byte_r[p] <= wr_dat[p];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      pend_r <= in_word;
    end else if (ctl.op == OP_DATA) begin
      pend_r <= pend_r << {take, 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pcnt_r  <= '0;
      plast_r <= 1'b0;
      blen_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (ctl.op == OP_LOAD) begin
        pcnt_r  <= cnt_sat;
        plast_r <= in_last;
        blen_r  <= blen_r + {58'd0, cnt_sat, 3'b000};
      end else if (ctl.op == OP_DATA) begin
        pcnt_r <= pcnt_r - take;
      end else if (ctl.op == OP_EMIT) begin
        blen_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1he_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working variables a..e, one compression round per cycle, and the chaining
// value with its feed-forward add and re-initialisation.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1he_round import sha1he_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  logic [31:0] wt,
  output chain_t      chain
);

  chain_t      chain_r;
  chain_t      work_r;
  chain_t      src;
  logic [31:0] a, b, c, d, e;
  logic [31:0] f, k, tmp;

  // round 0 starts from the chaining value
  assign src = (ctl.rnd == '0) ? chain_r : work_r;
  assign a = src[0];
  assign b = src[1];
  assign c = src[2];
  assign d = src[3];
  assign e = src[4];

  always_comb begin
    if (ctl.rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (ctl.rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (ctl.rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  assign tmp   = {a[26:0], a[31:27]} + f + e + k + wt;
  assign chain = chain_r;

  always_ff @(posedge clk) begin
    if (ctl.op == OP_ROUND) begin
      work_r[0] <= tmp;
      work_r[1] <= a;
      work_r[2] <= {b[1:0], b[31:2]};
      work_r[3] <= c;
      work_r[4] <= d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= H_INIT;
    end else if (ctl.op == OP_ADD) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end else if (ctl.op == OP_EMIT) begin
      chain_r <= H_INIT;
    end
  end

endmodule

`default_nettype wire
